>>> hdl/rtcdv_pkg.sv
// rtcdv_pkg: item types, calendar limits and small encode helpers for the
// rtc date/time validate and encode block. No dependencies.
package rtcdv_pkg;

  // calendar limits
  localparam logic [15:0] YearMin   = 16'd2000;
  localparam logic [15:0] YearMax   = 16'd2099;
  localparam logic [7:0]  MonthMax  = 8'd12;
  localparam logic [7:0]  HourMax   = 8'd23;
  localparam logic [7:0]  MinSecMax = 8'd59;
  localparam logic [3:0]  MonthFeb  = 4'd2;
  localparam logic [3:0]  MonthMar  = 4'd3;

  // input item: decimal calendar time
  typedef struct packed {
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
  } cal_in_t;

  // result item: clock register bytes
  typedef struct packed {
    logic       valid_res;
    logic [7:0] seconds_bcd;
    logic [7:0] minutes_bcd;
    logic [7:0] hours_bcd;
    logic [7:0] days_bcd;
    logic [2:0] weekday_code;
    logic [7:0] months_bcd;
    logic [7:0] years_bcd;
  } cal_out_t;

  // days in month m (1..12), february follows the leap flag
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    case (m)
      MonthFeb: month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      default: month_len = 5'd31;
    endcase
  endfunction

  // per-month weekday offset for the january/february shifted year
  function automatic logic [2:0] month_shift(input logic [3:0] m);
    case (m)
      4'd1:  month_shift = 3'd0;
      4'd2:  month_shift = 3'd3;
      4'd3:  month_shift = 3'd2;
      4'd4:  month_shift = 3'd5;
      4'd5:  month_shift = 3'd0;
      4'd6:  month_shift = 3'd3;
      4'd7:  month_shift = 3'd5;
      4'd8:  month_shift = 3'd1;
      4'd9:  month_shift = 3'd4;
      4'd10: month_shift = 3'd6;
      4'd11: month_shift = 3'd2;
      4'd12: month_shift = 3'd4;
      default: month_shift = 3'd0;
    endcase
  endfunction

  // packed bcd of 0..99; tens digit by reciprocal multiply (exact below 179)
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = {7'd0, v} * 14'd103;
    tens = prod[13:10];
    ones = v - ({3'd0, tens} << 3) - ({3'd0, tens} << 1);
    to_bcd = {tens, ones[3:0]};
  endfunction

  // x mod 7 by folding octal digits (8 = 1 mod 7)
  function automatic logic [2:0] mod7(input logic [7:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = 5'(x[7:6]) + 5'(x[5:3]) + 5'(x[2:0]);
    s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    mod7 = s2[2:0];
  endfunction

endpackage

>>> hdl/rtcdv_encode.sv
// rtcdv_encode: range checks, leap year, weekday and bcd packing for one item.
// Pure combinational; depends on rtcdv_pkg.
module rtcdv_encode
  import rtcdv_pkg::*;
(
  input  cal_in_t  cal,
  output cal_out_t enc
);

  logic [15:0] year_off;
  logic [6:0]  yy;
  logic [3:0]  mon;
  logic        year_ok;
  logic        month_ok;
  logic        time_ok;
  logic        day_ok;
  logic        leap;
  logic        jan_feb;
  logic [1:0]  adj;
  logic [7:0]  wsum;

  // year within the century, reduced to 0..99
  assign year_ok  = (cal.year >= YearMin) && (cal.year <= YearMax);
  assign year_off = cal.year - YearMin;
  assign yy       = year_off[6:0];

  // every year 2000..2099 divisible by four is leap (2000 is a 400 year)
  assign leap     = (yy[1:0] == 2'd0);

  // month, day and time limits
  assign mon      = cal.month[3:0];
  assign month_ok = (cal.month != 8'd0) && (cal.month <= MonthMax);
  assign time_ok  = (cal.hour <= HourMax) && (cal.minute <= MinSecMax) &&
                    (cal.second <= MinSecMax);
  assign day_ok   = (cal.day != 8'd0) && (cal.day <= {3'd0, month_len(mon, leap)});

  // weekday: year term is k + k/4 (century terms cancel mod 7);
  // january and february use the previous year
  assign jan_feb  = (mon < MonthMar);
  assign adj      = !jan_feb ? 2'd0 : (leap ? 2'd2 : 2'd1);
  assign wsum     = 8'(yy) + 8'(yy[6:2]) + 8'(month_shift(mon)) + 8'(cal.day[4:0])
                    + 8'd14 - 8'(adj);

  // result bytes, all zero on a failed check
  always_comb begin
    enc = '0;
    if (year_ok && month_ok && time_ok && day_ok) begin
      enc.valid_res    = 1'b1;
      enc.seconds_bcd  = to_bcd(cal.second[6:0]);
      enc.minutes_bcd  = to_bcd(cal.minute[6:0]);
      enc.hours_bcd    = to_bcd(cal.hour[6:0]);
      enc.days_bcd     = to_bcd(cal.day[6:0]);
      enc.weekday_code = mod7(wsum);
      enc.months_bcd   = to_bcd(cal.month[6:0]);
      enc.years_bcd    = to_bcd(yy);
    end
  end

endmodule

>>> hdl/rtc_datetime_validate_encode.sv
// rtc_datetime_validate_encode: top level, input register, encode logic and
// result register. Depends on rtcdv_pkg and rtcdv_encode.
//
// Usage:
//   cal channel: cal_valid / cal_stall / cal_data carry one calendar time per
//   item (year, month, day, hour, minute, second in plain binary).
//   enc channel: enc_valid / enc_stall / enc_data carry one result per item,
//   valid_res plus the clock register fields (packed bcd, weekday in
//   binary with 0 = sunday). A failed check gives valid_res = 0, bytes zero.
//   An item moves on an edge where valid is high and stall is low.
// Path: the input register then the result register, with
//   one encode pass of short logic between them.
// Throughput: one item per cycle while enc_stall is low; the input register
//   refills on the same edge that its item moves to the result register.
// Stall: while enc_stall holds a full result register, the input register
//   keeps its item and cal_stall rises only once both registers are full.
// Reset: rst (synchronous) empties both registers; no result is shown.
module rtc_datetime_validate_encode
  import rtcdv_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cal_valid,
  output logic     cal_stall,
  input  cal_in_t  cal_data,
  output logic     enc_valid,
  input  logic     enc_stall,
  output cal_out_t enc_data
);

  logic     s1_valid;
  cal_in_t  s1_data;
  cal_out_t enc_next;
  logic     out_ready;

  // handshake: result register frees when empty or taken
  assign out_ready = !enc_valid || !enc_stall;
  assign cal_stall = s1_valid && !out_ready;

  // encode pass
  rtcdv_encode u_encode (
    .cal (s1_data),
    .enc (enc_next)
  );

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      enc_valid <= 1'b0;
    end else begin
      if (!cal_stall) begin
        s1_valid <= cal_valid;
      end
      if (out_ready) begin
        enc_valid <= s1_valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cal_valid && !cal_stall) begin
      s1_data <= cal_data;
    end
    if (out_ready && s1_valid) begin
      enc_data <= enc_next;
    end
  end

  // a rejected item carries all-zero bytes
  a_zero_on_invalid: assert property (@(posedge clk) disable iff (rst)
    enc_valid && !enc_data.valid_res |-> enc_data == '0)
    else $error("invalid result with nonzero bytes");

  // weekday stays within sunday..saturday
  a_weekday_range: assert property (@(posedge clk) disable iff (rst)
    enc_valid && enc_data.valid_res |-> enc_data.weekday_code < 3'd7)
    else $error("weekday out of range");

  // stall on input only with a held item
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    cal_stall |-> s1_valid && enc_valid)
    else $error("input stalled with free register");

  // a held item moves to the output when the output is free
  a_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !enc_stall |=> enc_valid)
    else $error("held item did not advance");

endmodule
